[hw/rtl/hfd_pkg.sv]
// shared types and constants for the http/2 frame delineator
// no dependencies
`default_nettype none

package hfd_pkg;

   localparam int HdrBytes   = 9;
   localparam int HdrCountW  = 4;
   localparam int LenW       = 24;
   localparam int ByteW      = 8;
   localparam int StreamW    = 31;

   localparam logic [HdrCountW-1:0] HDR_LAST = HdrCountW'(HdrBytes);

   localparam logic [ByteW-1:0] RESERVED_CLEAR = 8'h7F;
   localparam logic [ByteW-1:0] BLOCK_END_MASK = 8'h04;

   localparam logic [ByteW-1:0] TYPE_HEADERS      = 8'h01;
   localparam logic [ByteW-1:0] TYPE_PUSH_PROMISE = 8'h05;
   localparam logic [ByteW-1:0] TYPE_CONTINUATION = 8'h09;

   // header byte positions
   localparam logic [HdrCountW-1:0] POS_LEN_HI  = 4'd0;
   localparam logic [HdrCountW-1:0] POS_LEN_MID = 4'd1;
   localparam logic [HdrCountW-1:0] POS_LEN_LO  = 4'd2;
   localparam logic [HdrCountW-1:0] POS_TYPE    = 4'd3;
   localparam logic [HdrCountW-1:0] POS_FLAGS   = 4'd4;
   localparam logic [HdrCountW-1:0] POS_SID_HI  = 4'd5;

   typedef enum logic {
      OP_BYTE  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   // one registered input beat
   typedef struct packed {
      logic             valid;
      op_type           op;
      logic [ByteW-1:0] data;
   } beat_type;

   // frame descriptor handed to the result register
   typedef struct packed {
      logic [LenW-1:0]    frame_length;
      logic [ByteW-1:0]   frame_type;
      logic [ByteW-1:0]   frame_flags;
      logic [StreamW-1:0] stream_id;
      logic               hdr_block_end;
   } desc_type;

endpackage

`default_nettype wire

[hw/rtl/hfd_input_stage.sv]
// input register for request beats
// depends on hfd_pkg
`default_nettype none

module hfd_input_stage import hfd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_op,
   input  wire logic [ByteW-1:0] req_data_byte,
   input  wire logic             advance,
   output beat_type              beat
);

   logic             valid_ff, valid_in;
   op_type           op_ff;
   logic [ByteW-1:0] data_ff;

   // slot is free when empty or being drained this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_ready && req_valid) begin
         op_ff   <= op_type'(req_op);
         data_ff <= req_data_byte;
      end
   end

   assign beat.valid = valid_ff;
   assign beat.op    = op_ff;
   assign beat.data  = data_ff;

endmodule

`default_nettype wire

[hw/rtl/hfd_frame_tracker.sv]
// frame header gathering and payload countdown
// depends on hfd_pkg
`default_nettype none

module hfd_frame_tracker import hfd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire beat_type beat,
   input  wire logic     fire,
   output logic          emit,
   output desc_type      desc
);

   logic [HdrCountW-1:0] count_ff, count_in;
   logic [LenW-1:0]      len_ff, len_in;
   logic [ByteW-1:0]     type_ff, type_in;
   logic [ByteW-1:0]     flags_ff, flags_in;
   logic [StreamW-1:0]   sid_ff, sid_in;
   logic [LenW-1:0]      left_ff, left_in;
   logic                 finish;

   always_comb begin
      count_in = count_ff;
      len_in   = len_ff;
      type_in  = type_ff;
      flags_in = flags_ff;
      sid_in   = sid_ff;
      left_in  = left_ff;
      finish   = 1'b0;
      if (fire) begin
         if (beat.op == OP_CLEAR) begin
            count_in = '0;
            len_in   = '0;
            type_in  = '0;
            flags_in = '0;
            sid_in   = '0;
            left_in  = '0;
         end else if (count_ff < HDR_LAST) begin
            unique case (count_ff)
               POS_LEN_HI:              len_in   = {{(LenW-ByteW){1'b0}}, beat.data};
               POS_LEN_MID, POS_LEN_LO: len_in   = {len_ff[LenW-ByteW-1:0], beat.data};
               POS_TYPE:                type_in  = beat.data;
               POS_FLAGS:               flags_in = beat.data;
               POS_SID_HI: begin
                  sid_in = {{(StreamW-7){1'b0}}, beat.data[6:0] & RESERVED_CLEAR[6:0]};
               end
               default:                 sid_in   = {sid_ff[StreamW-ByteW-1:0], beat.data};
            endcase
            count_in = count_ff + 1'b1;
            if (count_in == HDR_LAST) begin
               left_in = len_in;
               finish  = (len_in == '0);
            end
         end else begin
            // payload phase
            if (left_ff != '0) begin
               left_in = left_ff - 1'b1;
            end
            finish = (left_in == '0);
         end
         if (finish) begin
            count_in = '0;
            left_in  = '0;
         end
      end
   end

   assign emit = finish && (type_in == TYPE_HEADERS || type_in == TYPE_PUSH_PROMISE ||
                            type_in == TYPE_CONTINUATION);

   assign desc.frame_length  = len_in;
   assign desc.frame_type    = type_in;
   assign desc.frame_flags   = flags_in;
   assign desc.stream_id     = sid_in;
   assign desc.hdr_block_end = |(flags_in & BLOCK_END_MASK);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
         flags_ff <= '0;
         sid_ff   <= '0;
         left_ff  <= '0;
      end else begin
         count_ff <= count_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         flags_ff <= flags_in;
         sid_ff   <= sid_in;
         left_ff  <= left_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HDR_LAST)
      else $error("header count beyond nine");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      count_ff == HDR_LAST |-> left_ff != '0)
      else $error("payload phase with nothing left");

   a_emit_on_fire: assert property (@(posedge clock) disable iff (reset)
      emit |-> fire && beat.op == OP_BYTE)
      else $error("descriptor without a stream byte");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      fire && beat.op == OP_CLEAR |=> count_ff == '0 && left_ff == '0)
      else $error("clear left partial frame");

endmodule

`default_nettype wire

[hw/rtl/hfd_result_stage.sv]
// result register holding one frame descriptor
// depends on hfd_pkg
`default_nettype none

module hfd_result_stage import hfd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire desc_type desc,
   output logic          advance,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output desc_type      rsp_desc
);

   logic     valid_ff, valid_in;
   desc_type desc_ff;

   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance && load) begin
         desc_ff <= desc;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_desc  = desc_ff;

endmodule

`default_nettype wire

[hw/rtl/http2_frame_delineator_unit.sv]
// a frame's last byte is held in the input register, and its descriptor then loads into the result register
// throughput: one byte per clock, stalls only when the result register is full and held
// the frame state update is one short pass between input and result registers
// reset clears the frame state, both valid flags and the partial header at once
// depends on hfd_pkg, hfd_input_stage, hfd_frame_tracker, hfd_result_stage
`default_nettype none

module http2_frame_delineator_unit import hfd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   // request beats: one stream byte or a clear
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_op,
   input  wire logic [ByteW-1:0]   req_data_byte,
   // frame descriptors
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [LenW-1:0]         rsp_frame_length,
   output logic [ByteW-1:0]        rsp_frame_type,
   output logic [ByteW-1:0]        rsp_frame_flags,
   output logic [StreamW-1:0]      rsp_stream_id,
   output logic                    rsp_hdr_block_end
);

   beat_type beat;
   desc_type desc;
   desc_type rsp_desc;
   logic     advance;
   logic     fire;
   logic     emit;

   // input register, freed whenever the pipeline moves
   hfd_input_stage u_input (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .beat          (beat)
   );

   // a held beat is consumed only when the result register can take its outcome
   assign fire = beat.valid && advance;

   // header collection, payload countdown and descriptor selection
   hfd_frame_tracker u_tracker (
      .clock (clock),
      .reset (reset),
      .beat  (beat),
      .fire  (fire),
      .emit  (emit),
      .desc  (desc)
   );

   // output register decouples downstream stalls from the byte stream
   hfd_result_stage u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .desc      (desc),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_desc  (rsp_desc)
   );

   assign rsp_frame_length  = rsp_desc.frame_length;
   assign rsp_frame_type    = rsp_desc.frame_type;
   assign rsp_frame_flags   = rsp_desc.frame_flags;
   assign rsp_stream_id     = rsp_desc.stream_id;
   assign rsp_hdr_block_end = rsp_desc.hdr_block_end;

endmodule

`default_nettype wire

[sim/tb.sv]
// self-checking testbench for http2_frame_delineator_unit: random stream bytes,
// clears and frame sequences checked against an in-bench frame tracker
// depends on hfd_pkg and the rtl of http2_frame_delineator_unit
`timescale 1ns / 100ps

module tb;
   import hfd_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 300;

   // one pending request beat
   typedef struct packed {
      op_type           op;
      logic [ByteW-1:0] data;
   } stream_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   wire                req_ready;
   logic               req_op = OP_BYTE;
   logic [ByteW-1:0]   req_data_byte = '0;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire [LenW-1:0]     rsp_frame_length;
   wire [ByteW-1:0]    rsp_frame_type;
   wire [ByteW-1:0]    rsp_frame_flags;
   wire [StreamW-1:0]  rsp_stream_id;
   wire                rsp_hdr_block_end;

   stream_beat_type pending_beats[$];   // beats waiting for the driver
   desc_type        expected_frames[$]; // descriptors predicted, not yet seen

   int  beats_queued   = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  send_gap       = 0;
   int  take_stall     = 0;
   int  hold_left      = 0;
   bit  hold_request   = 1'b0;
   bit  hold_done      = 1'b0;
   bit  no_idle        = 1'b0;

   // frame tracker state, mirrors what the block keeps between beats
   logic [HdrCountW-1:0] hdr_seen   = '0;
   logic [LenW-1:0]      len_gather = '0;
   logic [ByteW-1:0]     type_seen  = '0;
   logic [ByteW-1:0]     flags_seen = '0;
   logic [StreamW-1:0]   sid_gather = '0;
   logic [LenW-1:0]      body_left  = '0;

   http2_frame_delineator_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_frame_flags   (rsp_frame_flags),
      .rsp_stream_id     (rsp_stream_id),
      .rsp_hdr_block_end (rsp_hdr_block_end)
   );

   always #5 clock = ~clock;

   // frame end: only header-block frame types give a descriptor
   function automatic bit close_frame(output desc_type frame);
      bit hit;
      frame = '0;
      hit = (type_seen == TYPE_HEADERS) || (type_seen == TYPE_PUSH_PROMISE) ||
            (type_seen == TYPE_CONTINUATION);
      if (hit) begin
         frame.frame_length  = len_gather;
         frame.frame_type    = type_seen;
         frame.frame_flags   = flags_seen;
         frame.stream_id     = sid_gather;
         frame.hdr_block_end = |(flags_seen & BLOCK_END_MASK);
      end
      hdr_seen  = '0;
      body_left = '0;
      return hit;
   endfunction

   // advance the tracker by one accepted beat, returns 1 when a descriptor is due
   function automatic bit track_beat(input op_type op, input logic [ByteW-1:0] b,
                                     output desc_type frame);
      frame = '0;
      if (op == OP_CLEAR) begin
         hdr_seen   = '0;
         len_gather = '0;
         type_seen  = '0;
         flags_seen = '0;
         sid_gather = '0;
         body_left  = '0;
         return 1'b0;
      end
      if (hdr_seen < HDR_LAST) begin
         case (hdr_seen)
            POS_LEN_HI:              len_gather = LenW'(b);
            POS_LEN_MID, POS_LEN_LO: len_gather = {len_gather[LenW-ByteW-1:0], b};
            POS_TYPE:                type_seen  = b;
            POS_FLAGS:               flags_seen = b;
            POS_SID_HI:              sid_gather = StreamW'(b & RESERVED_CLEAR);
            default:                 sid_gather = {sid_gather[StreamW-ByteW-1:0], b};
         endcase
         hdr_seen = hdr_seen + 1'b1;
         if (hdr_seen == HDR_LAST) begin
            body_left = len_gather;
            if (body_left == '0) return close_frame(frame);
         end
         return 1'b0;
      end
      // payload bytes are only counted
      if (body_left != '0) body_left = body_left - 1'b1;
      if (body_left == '0) return close_frame(frame);
      return 1'b0;
   endfunction

   task automatic push_beat(input op_type op, input logic [ByteW-1:0] b);
      pending_beats.push_back('{op: op, data: b});
      beats_queued++;
   endtask

   // queues the first keep bytes of a frame: 9 header bytes then random payload
   task automatic queue_frame(input logic [LenW-1:0] len, input logic [ByteW-1:0] ftype,
                              input logic [ByteW-1:0] flags, input logic [31:0] sid,
                              input int keep);
      logic [ByteW-1:0] hdr [0:HdrBytes-1];
      hdr[0] = len[23:16];
      hdr[1] = len[15:8];
      hdr[2] = len[7:0];
      hdr[3] = ftype;
      hdr[4] = flags;
      hdr[5] = sid[31:24];
      hdr[6] = sid[23:16];
      hdr[7] = sid[15:8];
      hdr[8] = sid[7:0];
      for (int i = 0; i < keep; i++)
         push_beat(OP_BYTE, (i < HdrBytes) ? hdr[i] : ByteW'($urandom));
   endtask

   function automatic logic [ByteW-1:0] random_block_type();
      case ($urandom_range(0, 2))
         0:       return TYPE_HEADERS;
         1:       return TYPE_PUSH_PROMISE;
         default: return TYPE_CONTINUATION;
      endcase
   endfunction

   // mostly short payloads, now and then a few hundred bytes
   function automatic logic [LenW-1:0] random_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return LenW'($urandom_range(0, 4));
      if (r < 95) return LenW'($urandom_range(5, 40));
      return LenW'($urandom_range(41, 300));
   endfunction

   // whole frames for the most part, with stray clears and cut-off frames
   task automatic queue_random_traffic(input int n_beats);
      int               stop_at;
      int               pick;
      int               cut_room;
      logic [LenW-1:0]  len;
      logic [ByteW-1:0] ftype;
      stop_at = beats_queued + n_beats;
      while (beats_queued < stop_at) begin
         pick  = $urandom_range(0, 99);
         ftype = $urandom_range(0, 1) ? random_block_type() : ByteW'($urandom);
         len   = random_len();
         if (pick < 70) begin
            queue_frame(len, ftype, ByteW'($urandom), $urandom, HdrBytes + int'(len));
         end else if (pick < 85) begin
            push_beat(OP_CLEAR, ByteW'($urandom));
         end else begin
            // frame abandoned part way, possibly with a huge declared length
            if ($urandom_range(0, 2) == 0) len = LenW'($urandom);
            cut_room = (len > 20) ? 20 : int'(len);
            queue_frame(len, ftype, ByteW'($urandom), $urandom,
                        $urandom_range(1, HdrBytes + cut_room));
            push_beat(OP_CLEAR, ByteW'($urandom));
         end
      end
   endtask

   // sender pause: nothing queued, nothing offered, nothing outstanding
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_frames.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // request driver: predicts on every accepted beat, then picks the next one
   always @(posedge clock) begin : request_driver
      desc_type        frame;
      stream_beat_type next_beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (track_beat(op_type'(req_op), req_data_byte, frame))
               expected_frames.push_back(frame);
         end
         if (req_valid && !req_ready) begin
            // hold the beat until taken
         end else if (send_gap > 0 && !no_idle) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            // idle burst, its length drawn at random
            send_gap = $urandom_range(0, 15);
            req_valid <= 1'b0;
         end else begin
            next_beat = pending_beats.pop_front();
            req_valid     <= 1'b1;
            req_op        <= next_beat.op;
            req_data_byte <= next_beat.data;
         end
      end
   end

   // result monitor: checks each descriptor beat, then sets up the next ready
   always @(posedge clock) begin : result_monitor
      desc_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected descriptor, expected none, actual len %0h type %0h",
                        $time, rsp_frame_length, rsp_frame_type);
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               compare_field("frame_length", 32'(want.frame_length), 32'(rsp_frame_length));
               compare_field("frame_type", 32'(want.frame_type), 32'(rsp_frame_type));
               compare_field("frame_flags", 32'(want.frame_flags), 32'(rsp_frame_flags));
               compare_field("stream_id", 32'(want.stream_id), 32'(rsp_stream_id));
               compare_field("hdr_block_end", 32'(want.hdr_block_end),
                             32'(rsp_hdr_block_end));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            // long back-pressure so the block fills and stalls its input
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            rsp_ready <= 1'b0;
         end else if (take_stall > 0 && !no_idle) begin
            take_stall--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            take_stall = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL http2_frame_delineator_unit");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty headers frame ending the block, reserved stream bit set
      queue_frame(24'd0, TYPE_HEADERS, BLOCK_END_MASK, 32'hFFFF_FFFF, HdrBytes);
      // continuation with a short payload, every flag but end-headers
      queue_frame(24'd2, TYPE_CONTINUATION, ~BLOCK_END_MASK, 32'h8000_0000, HdrBytes + 2);
      // maximum length and type cut off by a clear
      queue_frame(24'hFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4);
      push_beat(OP_CLEAR, 8'hFF);
      wait_drained();

      queue_random_traffic(400);
      wait_drained();

      // back-to-back empty header-block frames under a long receiver hold
      hold_request = 1'b1;
      repeat (16) queue_frame(24'd0, random_block_type(), ByteW'($urandom), $urandom, HdrBytes);
      wait_drained();

      queue_random_traffic(350);
      wait_drained();

      // closing stretch at full rate on both sides
      no_idle = 1'b1;
      queue_random_traffic(150);
      wait_drained();
      repeat (8) @(negedge clock);

      if (mismatch_count == 0 && expected_frames.size() == 0)
         $display("PASS http2_frame_delineator_unit");
      else
         $display("FAIL http2_frame_delineator_unit");
      $finish;
   end

endmodule
